### rtl/core/dmapt_pkg.sv
package dmapt_pkg;

  localparam int unsigned BUFFER_COUNT  = 2;
  localparam int unsigned EARLY_SHIFT   = 6;
  localparam int unsigned MAX_BUF_BYTES = 32768;
  localparam int unsigned MAX_BPS       = 16;

  localparam int unsigned RING_W = $clog2(MAX_BUF_BYTES * BUFFER_COUNT + 1);
  localparam int unsigned DIV_W  = RING_W;
  localparam int unsigned DSR_W  = 16;
  localparam int unsigned IDX_W  = $clog2(BUFFER_COUNT + 1);
  localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned OUT_W  = 112;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_QUERY   = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [1:0] REG_BUF_BYTES = 2'd0;
  localparam logic [1:0] REG_BPS       = 2'd1;
  localparam logic [1:0] REG_PLAYING   = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/core/dmapt_div.sv
module dmapt_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmapt_pkg::div_req_t req_i,
  output dmapt_pkg::div_rsp_t rsp_o
);
  import dmapt_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DSR_W-1:0] rem_q, rem_d;
  logic [DSR_W-1:0] dsr_q, dsr_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    diff   = trial - {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[DSR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DSR_W-1:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

### rtl/core/dma_ring_playback_position_tracker_unit.sv
// Playback position tracker for a ring of equal DMA buffers.
// Configuration arrives on the cfg channel: index 0 is the buffer size in bytes, index 1 the
// bytes per sample frame and index 2 the playing flag. The channel is always ready and must
// only be written while the block is idle.
// Each input beat carries the hardware play position in s_axis_tdata and the function in
// s_axis_tuser: a buffer-done tick, a position query or a restart. Every input beat yields
// exactly one output beat with the played sample count, the refill offset and the render
// sample position.
// All divisions run through one shared restoring divider. A tick needs two divisions, a
// query while playing one, and the other functions none. The first item after a write to
// the size registers runs two further divisions to refresh the cached buffer and ring
// lengths in samples.
// The block takes one item at a time; s_axis_tready is high only while it is idle. The
// result sits in an output register, so a new item is accepted while it waits; a stalled
// receiver holds the next result back at the last step.
// Reset restores the register defaults, clears all counters and empties the output register.
module dma_ring_playback_position_tracker_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // play_pos
  input  logic [1:0]                    s_axis_tuser,  // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [dmapt_pkg::OUT_W-1:0]   m_axis_tdata   // total_samples, render_offset,
                                                       // render_sample_pos
);
  import dmapt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DELTA = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  localparam logic [1:0] OP_BUF  = 2'd0;
  localparam logic [1:0] OP_RING = 2'd1;
  localparam logic [1:0] OP_POS  = 2'd2;
  localparam logic [1:0] OP_IDX  = 2'd3;

  function automatic logic need_pos(logic [1:0] f, logic p);
    return (f == FUNC_TICK) || ((f == FUNC_QUERY) && p);
  endfunction

  logic [15:0]       buf_bytes_q, buf_bytes_d;
  logic [4:0]        bps_q, bps_d;
  logic              playing_q, playing_d;
  logic [63:0]       played_q, played_d;
  logic [15:0]       last_q, last_d;
  logic [15:0]       refill_q, refill_d;
  logic [31:0]       render_q, render_d;
  logic [63:0]       floor_q, floor_d;
  logic              cache_ok_q, cache_ok_d;
  logic [2:0]        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic              m_valid_q, m_valid_d;

  logic [1:0]        func_q, func_d;
  logic [15:0]       pos_q, pos_d;
  logic [15:0]       buf_samp_q, buf_samp_d;
  logic [RING_W-1:0] ring_samp_q, ring_samp_d;
  logic [15:0]       now_q, now_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [63:0]       delta_q, delta_d;
  logic [OUT_W-1:0]  m_data_q, m_data_d;

  logic [15:0]       bsz;
  logic [4:0]        bps;
  logic [RING_W-1:0] ring;
  logic [RING_W-1:0] ring_top;
  logic [15:0]       pos_clamped;
  logic [IDX_W-1:0]  idx_w;
  logic [RING_W-1:0] off_w;
  logic [63:0]       sum;
  logic [63:0]       total;
  logic              in_beat;
  logic              do_pos;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dmapt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    if (buf_bytes_q == 16'd0) begin
      bsz = 16'd1;
    end else if (buf_bytes_q > 16'(MAX_BUF_BYTES)) begin
      bsz = 16'(MAX_BUF_BYTES);
    end else begin
      bsz = buf_bytes_q;
    end
    if (bps_q == 5'd0) begin
      bps = 5'd1;
    end else if (bps_q > 5'(MAX_BPS)) begin
      bps = 5'(MAX_BPS);
    end else begin
      bps = bps_q;
    end
    ring     = RING_W'(bsz) * RING_W'(BUFFER_COUNT);
    ring_top = ring - RING_W'(1);
    if (RING_W'(s_axis_tdata) > ring_top) begin
      pos_clamped = ring_top[15:0];
    end else begin
      pos_clamped = s_axis_tdata;
    end
  end

  always_comb begin
    div_req.start = (state_q == ST_LOAD);
    case (op_q)
      OP_BUF: begin
        div_req.dividend = DIV_W'(bsz);
        div_req.divisor  = DSR_W'(bps);
      end
      OP_RING: begin
        div_req.dividend = DIV_W'(ring);
        div_req.divisor  = DSR_W'(bps);
      end
      OP_POS: begin
        div_req.dividend = DIV_W'(pos_q);
        div_req.divisor  = DSR_W'(bps);
      end
      default: begin
        div_req.dividend = DIV_W'(pos_q) + DIV_W'(bsz >> EARLY_SHIFT);
        div_req.divisor  = bsz;
      end
    endcase
  end

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign do_pos  = need_pos(func_q, playing_q);

  always_comb begin
    if (idx_q >= IDX_W'(BUFFER_COUNT)) begin
      idx_w = idx_q - IDX_W'(BUFFER_COUNT);
    end else begin
      idx_w = idx_q;
    end
    off_w = (RING_W'(idx_w) + RING_W'(1)) * RING_W'(bsz);
    if (off_w >= ring) begin
      off_w = '0;
    end
    sum = played_q + delta_q;
  end

  always_comb begin
    buf_bytes_d = buf_bytes_q;
    bps_d       = bps_q;
    playing_d   = playing_q;
    played_d    = played_q;
    last_d      = last_q;
    refill_d    = refill_q;
    render_d    = render_q;
    floor_d     = floor_q;
    cache_ok_d  = cache_ok_q;
    state_d     = state_q;
    op_d        = op_q;
    m_valid_d   = m_valid_q;
    func_d      = func_q;
    pos_d       = pos_q;
    buf_samp_d  = buf_samp_q;
    ring_samp_d = ring_samp_q;
    now_d       = now_q;
    idx_d       = idx_q;
    delta_d     = delta_q;
    m_data_d    = m_data_q;
    total       = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BUF_BYTES: begin
          buf_bytes_d = cfg_data_i;
          cache_ok_d  = 1'b0;
        end
        REG_BPS: begin
          bps_d      = cfg_data_i[4:0];
          cache_ok_d = 1'b0;
        end
        REG_PLAYING: playing_d = cfg_data_i[0];
        default: ;
      endcase
    end

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          func_d = s_axis_tuser;
          pos_d  = pos_clamped;
          if (!cache_ok_q) begin
            op_d    = OP_BUF;
            state_d = ST_LOAD;
          end else if (need_pos(s_axis_tuser, playing_q)) begin
            op_d    = OP_POS;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_DELTA;
          end
        end
      end
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_LOAD;
          case (op_q)
            OP_BUF: begin
              buf_samp_d = div_rsp.quotient[15:0];
              op_d       = OP_RING;
            end
            OP_RING: begin
              ring_samp_d = div_rsp.quotient[RING_W-1:0];
              cache_ok_d  = 1'b1;
              if (do_pos) begin
                op_d = OP_POS;
              end else begin
                state_d = ST_DELTA;
              end
            end
            OP_POS: begin
              now_d = div_rsp.quotient[15:0];
              if (func_q == FUNC_TICK) begin
                op_d = OP_IDX;
              end else begin
                state_d = ST_DELTA;
              end
            end
            default: begin
              idx_d   = div_rsp.quotient[IDX_W-1:0];
              state_d = ST_DELTA;
            end
          endcase
        end
      end
      ST_DELTA: begin
        if (now_q < last_q) begin
          delta_d = 64'(ring_samp_q) + 64'(now_q) - 64'(last_q);
        end else begin
          delta_d = 64'(now_q - last_q);
        end
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          case (func_q)
            FUNC_TICK: begin
              refill_d = off_w[15:0];
              render_d = render_q + 32'(buf_samp_q);
              played_d = sum;
              last_d   = now_q;
              total    = sum;
            end
            FUNC_QUERY: begin
              if (playing_q) begin
                if (sum < floor_q) begin
                  total = floor_q;
                end else begin
                  floor_d = sum;
                  total   = sum;
                end
              end
            end
            FUNC_RESTART: begin
              render_d = 32'(buf_samp_q);
              played_d = '0;
              last_d   = '0;
              refill_d = bsz;
            end
            default: ;
          endcase
          m_data_d  = {render_d, refill_d, total};
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_bytes_q <= 16'd4096;
      bps_q       <= 5'd4;
      playing_q   <= 1'b0;
      played_q    <= '0;
      last_q      <= '0;
      refill_q    <= '0;
      render_q    <= '0;
      floor_q     <= '0;
      cache_ok_q  <= 1'b0;
      state_q     <= ST_IDLE;
      op_q        <= OP_BUF;
      m_valid_q   <= 1'b0;
    end else begin
      buf_bytes_q <= buf_bytes_d;
      bps_q       <= bps_d;
      playing_q   <= playing_d;
      played_q    <= played_d;
      last_q      <= last_d;
      refill_q    <= refill_d;
      render_q    <= render_d;
      floor_q     <= floor_d;
      cache_ok_q  <= cache_ok_d;
      state_q     <= state_d;
      op_q        <= op_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    pos_q       <= pos_d;
    buf_samp_q  <= buf_samp_d;
    ring_samp_q <= ring_samp_d;
    now_q       <= now_d;
    idx_q       <= idx_d;
    delta_q     <= delta_d;
    m_data_q    <= m_data_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> !s_axis_tready) else $error("input taken during a division");

  a_cache_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELTA) |-> cache_ok_q) else $error("finishing with stale sample lengths");

  a_floor_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    floor_q >= $past(floor_q)) else $error("query floor went backwards");

endmodule

### dv/dma_ring_playback_position_tracker_unit_test.sv
module dma_ring_playback_position_tracker_unit_test;
  import dmapt_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES = 16;
  localparam int unsigned PHASE_ITEMS = 96;

  typedef struct packed {
    logic [31:0] render_sample_pos;
    logic [15:0] render_offset;
    logic [63:0] total_samples;
  } position_beat_t;

  class tracker_scoreboard;
    logic [15:0] buf_bytes_reg = 16'd4096;
    logic [4:0]  bps_reg = 5'd4;
    logic        playing_reg = 1'b0;
    logic [63:0] played_count = '0;
    logic [15:0] last_sample_ptr = '0;
    logic [15:0] refill_offset = '0;
    logic [31:0] render_sample_count = '0;
    logic [63:0] query_floor = '0;
    position_beat_t expected_beats[$];
    int unsigned failures = 0;

    function void write_reg(logic [1:0] index, logic [15:0] data);
      case (index)
        REG_BUF_BYTES: buf_bytes_reg = data;
        REG_BPS:       bps_reg = data[4:0];
        REG_PLAYING:   playing_reg = data[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] samples_moved(logic [31:0] now, logic [31:0] ring_samples);
      if (now < 32'(last_sample_ptr)) begin
        return 64'(ring_samples) + 64'(now) - 64'(last_sample_ptr);
      end
      return 64'(now - 32'(last_sample_ptr));
    endfunction

    function position_beat_t track_position(logic [1:0] func, logic [15:0] raw_pos);
      logic [31:0] bsz, bps, ring, pos, idx, off, now;
      logic [63:0] sum;
      position_beat_t beat;
      bsz = (buf_bytes_reg == 16'd0) ? 32'd1 :
            (buf_bytes_reg > 16'd32768) ? 32'd32768 : 32'(buf_bytes_reg);
      bps = (bps_reg == 5'd0) ? 32'd1 : (bps_reg > 5'd16) ? 32'd16 : 32'(bps_reg);
      ring = BUFFER_COUNT * bsz;
      pos = (32'(raw_pos) > ring - 1) ? ring - 1 : 32'(raw_pos);
      beat.total_samples = '0;
      case (func)
        FUNC_TICK: begin
          idx = (pos + (bsz >> EARLY_SHIFT)) / bsz;
          if (idx >= BUFFER_COUNT) idx -= BUFFER_COUNT;
          off = (idx + 1) * bsz;
          if (off >= ring) off = 0;
          refill_offset = off[15:0];
          render_sample_count += bsz / bps;
          now = pos / bps;
          played_count += samples_moved(now, ring / bps);
          last_sample_ptr = now[15:0];
          beat.total_samples = played_count;
        end
        FUNC_QUERY: begin
          if (playing_reg) begin
            sum = played_count + samples_moved(pos / bps, ring / bps);
            if (sum < query_floor) begin
              beat.total_samples = query_floor;
            end else begin
              query_floor = sum;
              beat.total_samples = sum;
            end
          end
        end
        FUNC_RESTART: begin
          render_sample_count = bsz / bps;
          played_count = '0;
          last_sample_ptr = '0;
          refill_offset = bsz[15:0];
        end
        default: ;
      endcase
      beat.render_offset = refill_offset;
      beat.render_sample_pos = render_sample_count;
      return beat;
    endfunction

    function void note_item(logic [1:0] func, logic [15:0] raw_pos);
      expected_beats.push_back(track_position(func, raw_pos));
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      position_beat_t got, want;
      got = data;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: %h", data);
        failures++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.total_samples !== want.total_samples) begin
        $error("total_samples: expected %0d, actual %0d", want.total_samples,
               got.total_samples);
        failures++;
      end
      if (got.render_offset !== want.render_offset) begin
        $error("render_offset: expected %0d, actual %0d", want.render_offset,
               got.render_offset);
        failures++;
      end
      if (got.render_sample_pos !== want.render_sample_pos) begin
        $error("render_sample_pos: expected %0d, actual %0d", want.render_sample_pos,
               got.render_sample_pos);
        failures++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [1:0]       cfg_index_i;
  logic [15:0]      cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [15:0]      s_axis_tdata;
  logic [1:0]       s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  tracker_scoreboard sb = new();
  bit steady = 1'b0;
  int unsigned cycle_count;

  dma_ring_playback_position_tracker_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_item(logic [1:0] func, logic [15:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pos;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(func, pos);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_beats.size() != 0);
  endtask

  task automatic program_regs(logic [15:0] buf_bytes, logic [15:0] bps, logic [15:0] play);
    logic [1:0]  regs[3] = '{REG_BUF_BYTES, REG_BPS, REG_PLAYING};
    logic [15:0] values[3];
    values = '{buf_bytes, bps, play};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= values[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(regs[i], values[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [15:0] buf_choices[10];
    logic [15:0] bps_choices[8];
    logic [15:0] buf_bytes, bps;
    int unsigned eff_bsz, ring, cur, r;

    buf_choices = '{16'd1, 16'd32768, 16'd0, 16'hFFFF, 16'd3, 16'd64,
                    16'd100, 16'd4096, 16'd32767, 16'd40000};
    bps_choices = '{16'd1, 16'd16, 16'd0, 16'd31, 16'd4, 16'd3, 16'd2, 16'd17};
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_BUF_BYTES;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_TICK;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(FUNC_QUERY, 16'd0);
    send_item(FUNC_TICK, 16'hFFFF);
    send_item(FUNC_SPARE, 16'h5A5A);
    send_item(FUNC_RESTART, 16'hFFFF);
    send_item(FUNC_TICK, 16'd4031);
    send_item(FUNC_TICK, 16'd4032);
    send_item(FUNC_QUERY, 16'd8000);
    wait_drained();
    program_regs(16'd4096, 16'd4, 16'd1);
    send_item(FUNC_QUERY, 16'd8191);
    send_item(FUNC_QUERY, 16'd16);
    send_item(FUNC_QUERY, 16'd4032);
    send_item(FUNC_TICK, 16'd8191);
    send_item(FUNC_TICK, 16'd100);
    send_item(FUNC_RESTART, 16'd0);
    send_item(FUNC_QUERY, 16'd0);
    send_item(FUNC_SPARE, 16'hFFFF);
    wait_drained();
    program_regs(16'd0, 16'd0, 16'd1);
    send_item(FUNC_TICK, 16'hFFFF);
    send_item(FUNC_QUERY, 16'd0);
    wait_drained();
    program_regs(16'hFFFF, 16'd31, 16'd1);
    send_item(FUNC_TICK, 16'hFFFF);
    send_item(FUNC_TICK, 16'd32255);
    send_item(FUNC_QUERY, 16'h8000);
    send_item(FUNC_RESTART, 16'h1234);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      buf_bytes = (p < 10) ? buf_choices[p] : 16'($urandom_range(1, 32768));
      bps = (p < 8) ? bps_choices[p] : 16'($urandom_range(0, 31));
      program_regs(buf_bytes, bps, (p % 5 == 3) ? 16'd0 : 16'd1);
      eff_bsz = (buf_bytes == 0) ? 1 : (buf_bytes > 16'd32768) ? 32768 : buf_bytes;
      ring = BUFFER_COUNT * eff_bsz;
      cur = 0;
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 85) cur = (cur + $urandom_range(0, eff_bsz + eff_bsz / 8)) % ring;
        if (n == 0) begin
          send_item(FUNC_RESTART, 16'($urandom));
        end else if (r < 45) begin
          send_item(FUNC_TICK, 16'(cur));
        end else if (r < 85) begin
          send_item(FUNC_QUERY, 16'(cur));
        end else if (r < 95) begin
          send_item(2'($urandom_range(0, 3)), 16'($urandom));
        end else if (r < 97) begin
          send_item(FUNC_RESTART, 16'(cur));
        end else begin
          send_item(FUNC_SPARE, 16'(cur));
        end
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (sb.failures == 0 && sb.expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
